// ===== hdl/melody_tone_player_unit_assert.svh =====
// assertion helpers for the melody tone player
`ifndef MELODY_TONE_PLAYER_UNIT_ASSERT_SVH
`define MELODY_TONE_PLAYER_UNIT_ASSERT_SVH

// clocked assertion with a synchronous reset guard
`define MTP_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion on the block clock and reset
`define MTP_ASSERT(label, prop, msg) \
   `MTP_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ===== hdl/mtp_pkg.sv =====
`default_nettype none

package mtp_pkg;

   localparam int OP_W       = 1;
   localparam int NOTE_IDX_W = 6;
   localparam int TONE_W     = 15;
   localparam int LEN_W      = 16;
   localparam int ENTRY_W    = TONE_W + LEN_W;
   localparam int ML_W       = 7;
   localparam int PF_W       = 10;
   localparam int Q_FRAC     = 8;
   localparam int CSR_W      = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int TIME_W     = 28;
   localparam int HP_W       = 19;
   localparam int PASS_W     = 16;
   localparam int OUT_IDX_W  = 6;
   localparam int STEP_W     = 5;

   localparam logic [OP_W-1:0] OP_TICK  = 1'b0;
   localparam logic [OP_W-1:0] OP_WRITE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MELODY_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_FACTOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLAY_ENABLE   = 2'd2;

   localparam logic [ML_W-1:0]   ML_RESET = 7'd1;
   localparam logic [PF_W-1:0]   PF_RESET = 10'd102;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [PASS_W-1:0] PASS_MAX = {PASS_W{1'b1}};

   // half period in microseconds is this over the tone in hertz
   localparam logic [HP_W-1:0] HALF_PERIOD_DIVIDEND = 19'd500000;

   typedef enum logic [2:0] {
      PH_START,
      PH_REST,
      PH_HIGH,
      PH_LOW,
      PH_GAP
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_MUL_NOTE,
      ST_MUL_GAP,
      ST_APPLY,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/mtp_ram.sv =====
`default_nettype none

module mtp_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/melody_tone_player_unit.sv =====
// channel  | handshake               | payload
// ---------+-------------------------+-----------------------------------------------
// req      | req_valid / req_stall   | operation, note_index, note_tone_hz, length_ms
// rsp      | rsp_valid / rsp_stall   | pin_level, playing_index, repeat_count
// csr      | csr_we                  | csr_index, csr_wdata
//
// a write item or a tick with playback off goes straight to the result step, a wrap or a rest start
// passes through the load step, a tick inside a note runs one bit-serial multiply, a gap tick two,
// a tone start a bit-serial divide
// the note table is a single-port-write ram with registered read, one entry per item
// reset is synchronous and clears control state, the note table is not cleared
// one item is in work at a time; a held result on rsp stalls only the final step
`default_nettype none

`include "melody_tone_player_unit_assert.svh"

module melody_tone_player_unit #(
   parameter int TABLE_DEPTH  = 64,
   parameter int TICKS_PER_MS = 1000
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [mtp_pkg::OP_W-1:0]         req_operation,
   input  wire logic [mtp_pkg::NOTE_IDX_W-1:0]   req_note_index,
   input  wire logic [mtp_pkg::TONE_W-1:0]       req_note_tone_hz,
   input  wire logic [mtp_pkg::LEN_W-1:0]        req_note_length_ms,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_pin_level,
   output logic      [mtp_pkg::OUT_IDX_W-1:0]    rsp_playing_index,
   output logic      [mtp_pkg::PASS_W-1:0]       rsp_repeat_count,
   input  wire logic                             csr_we,
   input  wire logic [mtp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mtp_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int IW  = $clog2(TABLE_DEPTH + 1);
   localparam int KW  = $clog2(TICKS_PER_MS + 1);
   localparam int SW  = mtp_pkg::STEP_W;
   localparam int TMW = mtp_pkg::TIME_W;
   localparam int HPW = mtp_pkg::HP_W;
   localparam int TNW = mtp_pkg::TONE_W;
   localparam int LNW = mtp_pkg::LEN_W;
   localparam int PFW = mtp_pkg::PF_W;
   localparam int OIW = mtp_pkg::OUT_IDX_W;
   localparam int TW  = LNW + KW;
   localparam int GW  = TW + PFW - mtp_pkg::Q_FRAC;

   localparam logic [KW-1:0] TICKS     = KW'(TICKS_PER_MS);
   localparam logic [SW-1:0] DIV_LAST  = SW'(HPW - 1);
   localparam logic [SW-1:0] MULN_LAST = SW'(LNW - 1);
   localparam logic [SW-1:0] MULG_LAST = SW'(PFW - 1);

   mtp_pkg::state_type               state_ff, state_in;
   mtp_pkg::phase_type               phase_ff, phase_in;
   logic [IW-1:0]                    index_ff, index_in;
   logic [TMW-1:0]                   elapsed_ff, elapsed_in;
   logic [HPW-1:0]                   half_period_ff, half_period_in;
   logic [HPW-1:0]                   hp_elapsed_ff, hp_elapsed_in;
   logic                             level_ff, level_in;
   logic [mtp_pkg::PASS_W-1:0]       passes_ff, passes_in;
   logic [mtp_pkg::ML_W-1:0]         melody_length_ff, melody_length_in;
   logic [PFW-1:0]                   pause_factor_ff, pause_factor_in;
   logic                             play_enable_ff, play_enable_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic [SW-1:0]                    step_ff, step_in;
   logic [HPW-1:0]                   quo_ff, quo_in;
   logic [TNW-1:0]                   rem_ff, rem_in;
   logic [KW-1:0]                    t_hi_ff, t_hi_in;
   logic [LNW-1:0]                   t_lo_ff, t_lo_in;
   logic [TW-1:0]                    g_hi_ff, g_hi_in;
   logic [PFW-1:0]                   g_lo_ff, g_lo_in;
   logic                             rsp_pin_level_ff, rsp_pin_level_in;
   logic [OIW-1:0]                   rsp_playing_index_ff, rsp_playing_index_in;
   logic [mtp_pkg::PASS_W-1:0]       rsp_repeat_count_ff, rsp_repeat_count_in;

   logic                             ram_we;
   logic [mtp_pkg::ENTRY_W-1:0]      ram_rd_data;
   logic [TNW-1:0]                   rd_tone;
   logic [LNW-1:0]                   rd_len;
   logic                             write_in_range;
   logic                             rsp_load;

   logic [TNW:0]                     rem_shift;
   logic                             div_fits;
   logic [TNW-1:0]                   rem_next;
   logic [HPW-1:0]                   quo_next;
   logic [KW:0]                      t_sum;
   logic [TW:0]                      g_sum;
   logic [TW-1:0]                    t_full;
   logic [GW-1:0]                    gap_full;
   logic [TMW-1:0]                   note_limit;
   logic [TMW-1:0]                   gap_limit;
   logic [TMW-1:0]                   elapsed_inc;
   logic [HPW-1:0]                   hp_elapsed_inc;
   logic                             index_wraps;

   mtp_ram #(
      .WIDTH (mtp_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_note_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(req_note_index)),
      .wr_data ({req_note_tone_hz, req_note_length_ms}),
      .rd_addr (AW'(index_ff)),
      .rd_data (ram_rd_data)
   );

   assign rd_tone = ram_rd_data[mtp_pkg::ENTRY_W-1:LNW];
   assign rd_len  = ram_rd_data[LNW-1:0];

   assign write_in_range = 32'(req_note_index) < 32'(TABLE_DEPTH);

   // restoring divide, one quotient bit per cycle
   assign rem_shift = {rem_ff, quo_ff[HPW-1]};
   assign div_fits  = rem_shift >= {1'b0, rd_tone};
   assign rem_next  = div_fits ? TNW'(rem_shift - {1'b0, rd_tone}) : rem_shift[TNW-1:0];
   assign quo_next  = {quo_ff[HPW-2:0], div_fits};

   // shift-add multiplies, one multiplier bit per cycle
   assign t_sum    = {1'b0, t_hi_ff} + (t_lo_ff[0] ? {1'b0, TICKS} : '0);
   assign t_full   = {t_hi_ff, t_lo_ff};
   assign g_sum    = {1'b0, g_hi_ff} + (g_lo_ff[0] ? {1'b0, t_full} : '0);
   assign gap_full = {g_hi_ff, g_lo_ff[PFW-1:mtp_pkg::Q_FRAC]};

   assign note_limit = (64'(t_full) > 64'(mtp_pkg::TIME_MAX)) ? mtp_pkg::TIME_MAX
                                                               : TMW'(t_full);
   assign gap_limit  = (64'(gap_full) > 64'(mtp_pkg::TIME_MAX)) ? mtp_pkg::TIME_MAX
                                                                 : TMW'(gap_full);

   assign elapsed_inc    = (elapsed_ff == mtp_pkg::TIME_MAX) ? elapsed_ff
                                                             : elapsed_ff + TMW'(1);
   assign hp_elapsed_inc = hp_elapsed_ff + HPW'(1);

   assign index_wraps = (32'(index_ff) >= 32'(melody_length_ff)) ||
                        (32'(index_ff) >= 32'(TABLE_DEPTH));

   always_comb begin
      state_in             = state_ff;
      phase_in             = phase_ff;
      index_in             = index_ff;
      elapsed_in           = elapsed_ff;
      half_period_in       = half_period_ff;
      hp_elapsed_in        = hp_elapsed_ff;
      level_in             = level_ff;
      passes_in            = passes_ff;
      melody_length_in     = melody_length_ff;
      pause_factor_in      = pause_factor_ff;
      play_enable_in       = play_enable_ff;
      step_in              = step_ff;
      quo_in               = quo_ff;
      rem_in               = rem_ff;
      t_hi_in              = t_hi_ff;
      t_lo_in              = t_lo_ff;
      g_hi_in              = g_hi_ff;
      g_lo_in              = g_lo_ff;
      rsp_pin_level_in     = rsp_pin_level_ff;
      rsp_playing_index_in = rsp_playing_index_ff;
      rsp_repeat_count_in  = rsp_repeat_count_ff;
      ram_we               = 1'b0;
      rsp_load             = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            mtp_pkg::CSR_MELODY_LENGTH: melody_length_in = csr_wdata[mtp_pkg::ML_W-1:0];
            mtp_pkg::CSR_PAUSE_FACTOR:  pause_factor_in  = csr_wdata[PFW-1:0];
            mtp_pkg::CSR_PLAY_ENABLE:   play_enable_in   = csr_wdata[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         mtp_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == mtp_pkg::OP_WRITE) begin
                  ram_we   = write_in_range;
                  state_in = mtp_pkg::ST_DONE;
               end else if (play_enable_ff) begin
                  state_in = mtp_pkg::ST_LOAD;
               end else begin
                  state_in = mtp_pkg::ST_DONE;
               end
            end
         end

         mtp_pkg::ST_LOAD: begin
            step_in = '0;
            unique case (phase_ff)
               mtp_pkg::PH_START: begin
                  if (index_wraps) begin
                     index_in = '0;
                     if (passes_ff != mtp_pkg::PASS_MAX) begin
                        passes_in = passes_ff + mtp_pkg::PASS_W'(1);
                     end
                     state_in = mtp_pkg::ST_DONE;
                  end else if (rd_tone == '0) begin
                     elapsed_in    = '0;
                     hp_elapsed_in = '0;
                     level_in      = 1'b0;
                     phase_in      = mtp_pkg::PH_REST;
                     state_in      = mtp_pkg::ST_DONE;
                  end else begin
                     quo_in   = mtp_pkg::HALF_PERIOD_DIVIDEND;
                     rem_in   = '0;
                     state_in = mtp_pkg::ST_DIV;
                  end
               end
               mtp_pkg::PH_REST, mtp_pkg::PH_HIGH, mtp_pkg::PH_LOW, mtp_pkg::PH_GAP: begin
                  t_hi_in  = '0;
                  t_lo_in  = rd_len;
                  state_in = mtp_pkg::ST_MUL_NOTE;
               end
               default: begin
                  phase_in = mtp_pkg::PH_START;
                  state_in = mtp_pkg::ST_DONE;
               end
            endcase
         end

         mtp_pkg::ST_DIV: begin
            quo_in  = quo_next;
            rem_in  = rem_next;
            step_in = step_ff + SW'(1);
            if (step_ff == DIV_LAST) begin
               half_period_in = quo_next;
               elapsed_in     = '0;
               hp_elapsed_in  = '0;
               if (rd_len != '0) begin
                  level_in = 1'b1;
                  phase_in = mtp_pkg::PH_HIGH;
               end else begin
                  level_in = 1'b0;
                  phase_in = mtp_pkg::PH_GAP;
               end
               state_in = mtp_pkg::ST_DONE;
            end
         end

         mtp_pkg::ST_MUL_NOTE: begin
            t_hi_in = t_sum[KW:1];
            t_lo_in = {t_sum[0], t_lo_ff[LNW-1:1]};
            step_in = step_ff + SW'(1);
            if (step_ff == MULN_LAST) begin
               step_in = '0;
               if (phase_ff == mtp_pkg::PH_GAP) begin
                  g_hi_in  = '0;
                  g_lo_in  = pause_factor_ff;
                  state_in = mtp_pkg::ST_MUL_GAP;
               end else begin
                  state_in = mtp_pkg::ST_APPLY;
               end
            end
         end

         mtp_pkg::ST_MUL_GAP: begin
            g_hi_in = g_sum[TW:1];
            g_lo_in = {g_sum[0], g_lo_ff[PFW-1:1]};
            step_in = step_ff + SW'(1);
            if (step_ff == MULG_LAST) begin
               state_in = mtp_pkg::ST_APPLY;
            end
         end

         mtp_pkg::ST_APPLY: begin
            state_in = mtp_pkg::ST_DONE;
            unique case (phase_ff)
               mtp_pkg::PH_REST: begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= note_limit) begin
                     level_in   = 1'b0;
                     elapsed_in = '0;
                     phase_in   = mtp_pkg::PH_GAP;
                  end
               end
               mtp_pkg::PH_HIGH, mtp_pkg::PH_LOW: begin
                  elapsed_in    = elapsed_inc;
                  hp_elapsed_in = hp_elapsed_inc;
                  if (hp_elapsed_inc >= half_period_ff) begin
                     hp_elapsed_in = '0;
                     if (phase_ff == mtp_pkg::PH_HIGH) begin
                        level_in = 1'b0;
                        phase_in = mtp_pkg::PH_LOW;
                     end else if (elapsed_inc < note_limit) begin
                        level_in = 1'b1;
                        phase_in = mtp_pkg::PH_HIGH;
                     end else begin
                        level_in   = 1'b0;
                        elapsed_in = '0;
                        phase_in   = mtp_pkg::PH_GAP;
                     end
                  end
               end
               mtp_pkg::PH_GAP: begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= gap_limit) begin
                     index_in   = index_ff + IW'(1);
                     elapsed_in = '0;
                     phase_in   = mtp_pkg::PH_START;
                  end
               end
               default: phase_in = mtp_pkg::PH_START;
            endcase
         end

         mtp_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load             = 1'b1;
               rsp_pin_level_in     = play_enable_ff & level_ff;
               rsp_playing_index_in = OIW'(index_ff);
               rsp_repeat_count_in  = passes_ff;
               state_in             = mtp_pkg::ST_IDLE;
            end
         end

         default: state_in = mtp_pkg::ST_IDLE;
      endcase

      rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= mtp_pkg::ST_IDLE;
         phase_ff         <= mtp_pkg::PH_START;
         index_ff         <= '0;
         elapsed_ff       <= '0;
         half_period_ff   <= '0;
         hp_elapsed_ff    <= '0;
         level_ff         <= 1'b0;
         passes_ff        <= '0;
         melody_length_ff <= mtp_pkg::ML_RESET;
         pause_factor_ff  <= mtp_pkg::PF_RESET;
         play_enable_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         phase_ff         <= phase_in;
         index_ff         <= index_in;
         elapsed_ff       <= elapsed_in;
         half_period_ff   <= half_period_in;
         hp_elapsed_ff    <= hp_elapsed_in;
         level_ff         <= level_in;
         passes_ff        <= passes_in;
         melody_length_ff <= melody_length_in;
         pause_factor_ff  <= pause_factor_in;
         play_enable_ff   <= play_enable_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff              <= step_in;
      quo_ff               <= quo_in;
      rem_ff               <= rem_in;
      t_hi_ff              <= t_hi_in;
      t_lo_ff              <= t_lo_in;
      g_hi_ff              <= g_hi_in;
      g_lo_ff              <= g_lo_in;
      rsp_pin_level_ff     <= rsp_pin_level_in;
      rsp_playing_index_ff <= rsp_playing_index_in;
      rsp_repeat_count_ff  <= rsp_repeat_count_in;
   end

   assign req_stall         = (state_ff != mtp_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pin_level     = rsp_pin_level_ff;
   assign rsp_playing_index = rsp_playing_index_ff;
   assign rsp_repeat_count  = rsp_repeat_count_ff;

   // pin is high exactly in the high half of a tone
   `MTP_ASSERT(a_level_tracks_phase, level_ff == (phase_ff == mtp_pkg::PH_HIGH), "pin level out of step with phase")
   `MTP_ASSERT(a_index_bounded, 32'(index_ff) <= 32'(TABLE_DEPTH), "note index past table end")
   `MTP_ASSERT(a_accept_goes_busy, (req_valid && !req_stall) |=> (state_ff != mtp_pkg::ST_IDLE), "accepted item left block idle")

endmodule

`default_nettype wire

// ===== sim/melody_checker.sv =====
module melody_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic [mtp_pkg::OP_W-1:0]         req_operation,
   input  wire logic [mtp_pkg::NOTE_IDX_W-1:0]   req_note_index,
   input  wire logic [mtp_pkg::TONE_W-1:0]       req_note_tone_hz,
   input  wire logic [mtp_pkg::LEN_W-1:0]        req_note_length_ms,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic                             rsp_pin_level,
   input  wire logic [mtp_pkg::OUT_IDX_W-1:0]    rsp_playing_index,
   input  wire logic [mtp_pkg::PASS_W-1:0]       rsp_repeat_count,
   input  wire logic                             csr_we,
   input  wire logic [mtp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mtp_pkg::CSR_W-1:0]        csr_wdata,
   output int                                    fail_count,
   output int                                    pending_items
);
   timeunit 1ns;
   timeprecision 1ps;

   import mtp_pkg::*;

   localparam int unsigned TABLE_DEPTH  = 64;
   localparam int unsigned TICKS_PER_MS = 1000;
   localparam int unsigned HALF_WAVE_US = 500000;

   typedef struct packed {
      logic                 pin;
      logic [OUT_IDX_W-1:0] idx;
      logic [PASS_W-1:0]    passes;
   } player_status_type;

   player_status_type expected_status[$];
   player_status_type want;
   int                mismatches;

   // copy of the register file
   logic [ML_W-1:0] melody_len;
   logic [PF_W-1:0] pause_q8;
   logic            play_on;

   // copy of the player state
   logic [TONE_W-1:0] tone_mem [TABLE_DEPTH];
   logic [LEN_W-1:0]  len_mem [TABLE_DEPTH];
   phase_type         ph;
   int unsigned       note_cursor;
   logic [TIME_W-1:0] elapsed;
   logic [HP_W-1:0]   half_period;
   logic [HP_W-1:0]   half_elapsed;
   logic              level;
   logic [PASS_W-1:0] passes;

   function automatic logic [TIME_W-1:0] sat_time(longint unsigned t);
      if (t > longint'({TIME_W{1'b1}})) return '1;
      return t[TIME_W-1:0];
   endfunction

   function automatic longint unsigned note_span_us();
      if (note_cursor < TABLE_DEPTH)
         return longint'(len_mem[note_cursor]) * TICKS_PER_MS;
      return 0;
   endfunction

   function automatic logic [TIME_W-1:0] note_limit();
      return sat_time(note_span_us());
   endfunction

   function automatic logic [TIME_W-1:0] gap_limit();
      return sat_time((note_span_us() * pause_q8) >> Q_FRAC);
   endfunction

   function automatic void start_gap();
      level   = 1'b0;
      elapsed = '0;
      ph      = PH_GAP;
   endfunction

   function automatic void advance_tick();
      int unsigned eff_len;
      eff_len = (melody_len > TABLE_DEPTH) ? TABLE_DEPTH : melody_len;
      case (ph)
         PH_START: begin
            if (note_cursor >= eff_len) begin
               note_cursor = 0;
               if (passes != '1) passes++;
            end else begin
               elapsed      = '0;
               half_elapsed = '0;
               if (tone_mem[note_cursor] == '0) begin
                  level = 1'b0;
                  ph    = PH_REST;
               end else begin
                  half_period = HP_W'(HALF_WAVE_US / tone_mem[note_cursor]);
                  if (note_limit() != '0) begin
                     level = 1'b1;
                     ph    = PH_HIGH;
                  end else begin
                     start_gap();
                  end
               end
            end
         end
         PH_REST: begin
            if (elapsed != '1) elapsed++;
            if (elapsed >= note_limit()) start_gap();
         end
         PH_HIGH, PH_LOW: begin
            if (elapsed != '1) elapsed++;
            half_elapsed++;
            if (half_elapsed >= half_period) begin
               half_elapsed = '0;
               if (ph == PH_HIGH) begin
                  level = 1'b0;
                  ph    = PH_LOW;
               end else if (elapsed < note_limit()) begin
                  level = 1'b1;
                  ph    = PH_HIGH;
               end else begin
                  start_gap();
               end
            end
         end
         PH_GAP: begin
            if (elapsed != '1) elapsed++;
            if (elapsed >= gap_limit()) begin
               note_cursor++;
               elapsed = '0;
               ph      = PH_START;
            end
         end
         default: ph = PH_START;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         melody_len   = ML_RESET;
         pause_q8     = PF_RESET;
         play_on      = 1'b0;
         ph           = PH_START;
         note_cursor  = 0;
         elapsed      = '0;
         half_period  = '0;
         half_elapsed = '0;
         level        = 1'b0;
         passes       = '0;
         mismatches   = 0;
         expected_status.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MELODY_LENGTH: melody_len = csr_wdata[ML_W-1:0];
               CSR_PAUSE_FACTOR:  pause_q8   = csr_wdata[PF_W-1:0];
               CSR_PLAY_ENABLE:   play_on    = csr_wdata[0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_status.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with none pending: pin %0b index %0d count %0d",
                           $time, rsp_pin_level, rsp_playing_index, rsp_repeat_count);
            end else begin
               want = expected_status.pop_front();
               if (rsp_pin_level !== want.pin || rsp_playing_index !== want.idx ||
                   rsp_repeat_count !== want.passes) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: result mismatch: expected pin %0b index %0d count %0d,",
                               " got pin %0b index %0d count %0d"},
                              $time, want.pin, want.idx, want.passes,
                              rsp_pin_level, rsp_playing_index, rsp_repeat_count);
               end
            end
         end

         if (req_valid && !req_stall) begin
            if (req_operation == OP_WRITE) begin
               tone_mem[req_note_index] = req_note_tone_hz;
               len_mem[req_note_index]  = req_note_length_ms;
            end else if (play_on) begin
               advance_tick();
            end
            expected_status.push_back('{play_on & level, note_cursor[OUT_IDX_W-1:0], passes});
         end
      end
      fail_count    <= mismatches;
      pending_items <= expected_status.size();
   end

endmodule

// ===== sim/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mtp_pkg::*;

   localparam int unsigned TABLE_DEPTH = 64;
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          ITEM_TARGET = 1200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_operation = OP_TICK;
   logic [NOTE_IDX_W-1:0] req_note_index = '0;
   logic [TONE_W-1:0]     req_note_tone_hz = '0;
   logic [LEN_W-1:0]      req_note_length_ms = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_pin_level;
   logic [OUT_IDX_W-1:0]  rsp_playing_index;
   logic [PASS_W-1:0]     rsp_repeat_count;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_MELODY_LENGTH;
   logic [CSR_W-1:0]      csr_wdata = '0;
   int                    fail_count;
   int                    pending_items;

   // stimulus bookkeeping, kept to steer playback away from long notes
   bit                    note_written [TABLE_DEPTH];
   logic [LEN_W-1:0]      note_len_kept [TABLE_DEPTH];
   int unsigned           melody_span = 1;
   bit                    play_now = 1'b0;
   bit                    req_lazy = 1'b1;
   bit                    rsp_lazy = 1'b1;
   int                    items_done = 0;
   int unsigned           stall_left = 0;
   int unsigned           rsp_hold;
   int                    cycle_count;

   melody_tone_player_unit i_dut (.*);

   melody_checker i_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_hold = rsp_lazy ? $urandom_range(0, 19) : 0;
         rsp_stall  <= (rsp_hold != 0);
         stall_left <= rsp_hold;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_left <= 0;
         rsp_stall  <= 1'b0;
      end
   end

   task automatic send_item(logic [OP_W-1:0] op, logic [NOTE_IDX_W-1:0] idx,
                            logic [TONE_W-1:0] tone, logic [LEN_W-1:0] len);
      int unsigned gap;
      gap = req_lazy ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= op;
      req_note_index     <= idx;
      req_note_tone_hz   <= tone;
      req_note_length_ms <= len;
      do @(posedge clock); while (req_stall);
      if (op == OP_WRITE) begin
         note_written[idx]  = 1'b1;
         note_len_kept[idx] = len;
      end
      if (op == OP_WRITE || play_now) items_done++;
   endtask

   task automatic send_tick();
      send_item(OP_TICK, NOTE_IDX_W'($urandom), TONE_W'($urandom_range(0, 20000)),
                LEN_W'($urandom));
   endtask

   // wait until every item has come back
   task automatic settle_player();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_items != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void pick_short_note(output logic [TONE_W-1:0] tone,
                                           output logic [LEN_W-1:0] len);
      len = ($urandom_range(0, 15) == 0) ? LEN_W'(1) : '0;
      if ($urandom_range(0, 3) == 0)
         tone = '0;
      else if (len != '0)
         tone = TONE_W'($urandom_range(2000, 20000));
      else
         tone = TONE_W'($urandom_range(1, 20000));
   endfunction

   task automatic start_phase(logic [ML_W-1:0] ml, logic [PF_W-1:0] pf, logic en);
      int unsigned       span;
      logic [TONE_W-1:0] tone;
      logic [LEN_W-1:0]  len;
      logic [CSR_W-1:0]  data;
      span = (ml > TABLE_DEPTH) ? TABLE_DEPTH : ml;
      settle_player();
      // every entry in use must be written and short
      for (int i = 0; i < span; i++) begin
         if (!note_written[i] || note_len_kept[i] > 1) begin
            pick_short_note(tone, len);
            send_item(OP_WRITE, NOTE_IDX_W'(i), tone, len);
         end
      end
      settle_player();
      write_reg(CSR_PAUSE_FACTOR, pf);
      data = CSR_W'($urandom);
      data[ML_W-1:0] = ml;
      write_reg(CSR_MELODY_LENGTH, data);
      data = CSR_W'($urandom);
      data[0] = en;
      write_reg(CSR_PLAY_ENABLE, data);
      melody_span = span;
      play_now    = en;
      req_lazy    = ($urandom_range(0, 3) != 0);
      rsp_lazy    = ($urandom_range(0, 3) != 0);
   endtask

   task automatic play_stretch(int unsigned count);
      logic [NOTE_IDX_W-1:0] idx;
      logic [TONE_W-1:0]     tone;
      logic [LEN_W-1:0]      len;
      repeat (count) begin
         if ($urandom_range(0, 99) == 0) settle_player();
         if ($urandom_range(0, 3) != 0) begin
            send_tick();
         end else begin
            if (melody_span != 0 && $urandom_range(0, 1) == 1)
               idx = NOTE_IDX_W'($urandom_range(0, melody_span - 1));
            else
               idx = NOTE_IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
            if (idx >= melody_span && $urandom_range(0, 1) == 1) begin
               tone = TONE_W'($urandom_range(0, 20000));
               len  = LEN_W'($urandom);
            end else begin
               pick_short_note(tone, len);
            end
            send_item(OP_WRITE, idx, tone, len);
         end
      end
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   initial begin
      int               phase_no;
      logic [ML_W-1:0]  ml;
      logic [PF_W-1:0]  pf;
      logic             en;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // tick with playback off, then a small melody of edge notes
      send_tick();
      send_item(OP_WRITE, 6'd0, 15'd0, 16'd0);
      send_item(OP_WRITE, 6'd1, 15'd20000, 16'd0);
      send_item(OP_WRITE, 6'd2, 15'd1, 16'd0);
      send_item(OP_WRITE, 6'd3, 15'd20000, 16'd1);
      send_item(OP_WRITE, 6'd63, 15'd20000, 16'hFFFF);
      // empty melody: every tick wraps
      start_phase(7'd0, 10'd1023, 1'b1);
      repeat (3) send_tick();
      // rest, zero-length tones, then a real tone cut short while it plays
      start_phase(7'd4, 10'd0, 1'b1);
      repeat (12) send_tick();
      send_item(OP_WRITE, 6'd3, 15'd20000, 16'd0);
      repeat (6) send_tick();

      phase_no = 0;
      while (items_done < ITEM_TARGET) begin
         case (phase_no)
            0: begin ml = 7'd2;   pf = 10'd0;    en = 1'b1; end
            1: begin ml = 7'd64;  pf = 10'd1023; en = 1'b1; end
            2: begin ml = 7'd127; pf = 10'd0;    en = 1'b1; end
            3: begin ml = 7'd0;   pf = 10'd512;  en = 1'b1; end
            4: begin ml = 7'd1;   pf = 10'd1;    en = 1'b0; end
            default: begin
               case ($urandom_range(0, 4))
                  0, 1:    ml = ML_W'($urandom_range(1, 8));
                  2:       ml = ML_W'($urandom_range(0, 127));
                  default: ml = ML_W'($urandom_range(1, 64));
               endcase
               pf = PF_W'($urandom_range(0, 1023));
               en = ($urandom_range(0, 5) != 0);
            end
         endcase
         start_phase(ml, pf, en);
         play_stretch(en ? $urandom_range(60, 180) : $urandom_range(10, 30));
         phase_no++;
      end

      settle_player();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
